@@ rtl/scp_pkg.sv @@
// ----------------------------------------------------------------------------
// scp_pkg: types and constants of the sensor command parser
// Command codes, candidate word spellings and the special characters that
// the parser compares against.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

  typedef enum logic [2:0] {
    CMD_OFF   = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_START = 3'd2,
    CMD_SCALE = 3'd3,
    CMD_FREQ  = 3'd4
  } cmd_e;

  localparam int unsigned NumWords = 5;

  typedef logic [NumWords-1:0] word_mask_t;

  localparam word_mask_t ALL_WORDS = '1;

  // Lengths of the command words
  localparam int unsigned LEN_OFF   = 3;
  localparam int unsigned LEN_STOP  = 4;
  localparam int unsigned LEN_START = 5;
  localparam int unsigned LEN_SCALE = 5;
  localparam int unsigned LEN_FREQ  = 4;

  // Position of the scale letter and shortest valid lengths
  localparam int unsigned POS_SCALE_LETTER = 6;
  localparam int unsigned MIN_LEN_SCALE    = 7;
  localparam int unsigned MIN_LEN_FREQ     = 6;

  localparam logic [7:0] CHAR_EQ   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_F    = 8'h46;  // 'F'
  localparam logic [7:0] CHAR_C    = 8'h43;  // 'C'
  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE = 8'h39;  // '9'

  localparam logic [13:0] PERIOD_MAX   = 14'd9999;
  localparam logic [13:0] PERIOD_RESET = 14'd3;

  // Character of a command word at a position; positions past the end of
  // the word must be excluded by the caller.
  function automatic logic [7:0] word_char(cmd_e word, logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (word)
      CMD_OFF: begin
        case (pos)
          3'd0:    c = "O";
          3'd1:    c = "F";
          3'd2:    c = "F";
          default: c = 8'h00;
        endcase
      end
      CMD_STOP: begin
        case (pos)
          3'd0:    c = "S";
          3'd1:    c = "T";
          3'd2:    c = "O";
          3'd3:    c = "P";
          default: c = 8'h00;
        endcase
      end
      CMD_START: begin
        case (pos)
          3'd0:    c = "S";
          3'd1:    c = "T";
          3'd2:    c = "A";
          3'd3:    c = "R";
          3'd4:    c = "T";
          default: c = 8'h00;
        endcase
      end
      CMD_SCALE: begin
        case (pos)
          3'd0:    c = "S";
          3'd1:    c = "C";
          3'd2:    c = "A";
          3'd3:    c = "L";
          3'd4:    c = "E";
          default: c = 8'h00;
        endcase
      end
      CMD_FREQ: begin
        case (pos)
          3'd0:    c = "F";
          3'd1:    c = "R";
          3'd2:    c = "E";
          3'd3:    c = "Q";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sensor_command_parser.sv @@
// ----------------------------------------------------------------------------
// sensor_command_parser: character-serial command parser
// One character beat is taken per cycle; a beat marked last yields one
// result beat in the output register on the following cycle.
// Throughput is one character per cycle, set by the single matching and
// digit-accumulation stage; a result that is not taken holds off further
// character beats until it is.
// Reset restores the settings (on, running, Fahrenheit, period 3) at once.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_command_parser import scp_pkg::*; #(
  parameter int unsigned MAX_MSG_LEN = 9
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  ch_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             valid_res_o,
  output logic [2:0]       command_o,
  output logic             powered_on_o,
  output logic             running_o,
  output logic             celsius_o,
  output logic [13:0]      period_o
);

  localparam int unsigned CntW = $clog2(MAX_MSG_LEN + 1);

  // Per-message state
  logic [CntW-1:0] cnt_q, cnt_d;
  word_mask_t      mask_q, mask_d;
  logic            bad_q, bad_d;
  logic            letter_q, letter_d;
  logic [13:0]     digits_q, digits_d;
  logic [2:0]      ndig_q, ndig_d;

  // Settings
  logic            on_q, on_d;
  logic            run_q, run_d;
  logic            scale_q, scale_d;
  logic [13:0]     period_q, period_d;

  // Output register
  logic            out_valid_q, out_valid_d;
  logic            res_valid_q, res_valid_d;
  cmd_e            res_cmd_q, res_cmd_d;

  logic            in_fire;
  logic [2:0]      pos;
  logic            is_digit;
  logic [16:0]     acc;
  logic            msg_ok;
  cmd_e            msg_cmd;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  // Only used while the position lies inside a word, so well below eight.
  assign pos        = cnt_q[2:0];
  assign is_digit   = (ch_i >= CHAR_ZERO) && (ch_i <= CHAR_NINE);
  assign acc        = {digits_q, 3'b000} + {2'b00, digits_q, 1'b0}
                      + {13'd0, ch_i[3:0]};

  always_comb begin
    cnt_d       = cnt_q;
    mask_d      = mask_q;
    bad_d       = bad_q;
    letter_d    = letter_q;
    digits_d    = digits_q;
    ndig_d      = ndig_q;
    on_d        = on_q;
    run_d       = run_q;
    scale_d     = scale_q;
    period_d    = period_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_valid_d = res_valid_q;
    res_cmd_d   = res_cmd_q;
    msg_ok      = 1'b0;
    msg_cmd     = CMD_OFF;

    if (in_fire) begin
      if (cnt_q >= CntW'(MAX_MSG_LEN)) begin
        bad_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end

      if (!(cnt_q < CntW'(LEN_OFF) && ch_i == word_char(CMD_OFF, pos))) begin
        mask_d[CMD_OFF] = 1'b0;
      end
      if (!(cnt_q < CntW'(LEN_STOP) && ch_i == word_char(CMD_STOP, pos))) begin
        mask_d[CMD_STOP] = 1'b0;
      end
      if (!(cnt_q < CntW'(LEN_START) && ch_i == word_char(CMD_START, pos))) begin
        mask_d[CMD_START] = 1'b0;
      end

      if (cnt_q < CntW'(LEN_SCALE)) begin
        if (ch_i != word_char(CMD_SCALE, pos)) mask_d[CMD_SCALE] = 1'b0;
      end else if (cnt_q == CntW'(LEN_SCALE)) begin
        if (ch_i != CHAR_EQ) mask_d[CMD_SCALE] = 1'b0;
      end else if (cnt_q == CntW'(POS_SCALE_LETTER)) begin
        if (ch_i == CHAR_C) begin
          letter_d = 1'b1;
        end else if (ch_i == CHAR_F) begin
          letter_d = 1'b0;
        end else begin
          mask_d[CMD_SCALE] = 1'b0;
        end
      end

      if (cnt_q < CntW'(LEN_FREQ)) begin
        if (ch_i != word_char(CMD_FREQ, pos)) mask_d[CMD_FREQ] = 1'b0;
      end else if (cnt_q == CntW'(LEN_FREQ)) begin
        if (ch_i != CHAR_EQ) mask_d[CMD_FREQ] = 1'b0;
      end else if (!is_digit) begin
        mask_d[CMD_FREQ] = 1'b0;
      end else if (mask_q[CMD_FREQ] && !bad_d) begin
        digits_d = (acc > {3'b000, PERIOD_MAX}) ? PERIOD_MAX : acc[13:0];
        if (ndig_q != 3'd7) ndig_d = ndig_q + 3'd1;
      end

      if (last_i) begin
        // Decide on the message with the state as updated by this beat.
        if (!bad_d) begin
          if (mask_d[CMD_OFF] && cnt_d == CntW'(LEN_OFF)) begin
            msg_ok  = 1'b1;
            msg_cmd = CMD_OFF;
            on_d    = 1'b0;
          end else if (mask_d[CMD_STOP] && cnt_d == CntW'(LEN_STOP)) begin
            msg_ok  = 1'b1;
            msg_cmd = CMD_STOP;
            run_d   = 1'b0;
          end else if (mask_d[CMD_START] && cnt_d == CntW'(LEN_START)) begin
            msg_ok  = 1'b1;
            msg_cmd = CMD_START;
            run_d   = 1'b1;
          end else if (mask_d[CMD_SCALE] && cnt_d >= CntW'(MIN_LEN_SCALE)) begin
            msg_ok  = 1'b1;
            msg_cmd = CMD_SCALE;
            scale_d = letter_d;
          end else if (mask_d[CMD_FREQ] && cnt_d >= CntW'(MIN_LEN_FREQ)
                       && ndig_d != 3'd0) begin
            msg_ok   = 1'b1;
            msg_cmd  = CMD_FREQ;
            period_d = digits_d;
          end
        end

        out_valid_d = 1'b1;
        res_valid_d = msg_ok;
        res_cmd_d   = msg_cmd;

        cnt_d    = '0;
        mask_d   = ALL_WORDS;
        bad_d    = 1'b0;
        letter_d = 1'b0;
        digits_d = '0;
        ndig_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      mask_q      <= ALL_WORDS;
      bad_q       <= 1'b0;
      letter_q    <= 1'b0;
      digits_q    <= '0;
      ndig_q      <= '0;
      on_q        <= 1'b1;
      run_q       <= 1'b1;
      scale_q     <= 1'b0;
      period_q    <= PERIOD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      mask_q      <= mask_d;
      bad_q       <= bad_d;
      letter_q    <= letter_d;
      digits_q    <= digits_d;
      ndig_q      <= ndig_d;
      on_q        <= on_d;
      run_q       <= run_d;
      scale_q     <= scale_d;
      period_q    <= period_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; the settings are taken from their registers, which by
  // then hold the values applied by the message.
  always_ff @(posedge clk_i) begin
    res_valid_q <= res_valid_d;
    res_cmd_q   <= res_cmd_d;
  end

  assign out_valid_o  = out_valid_q;
  assign valid_res_o  = res_valid_q;
  assign command_o    = res_cmd_q;
  assign powered_on_o = on_q;
  assign running_o    = run_q;
  assign celsius_o    = scale_q;
  assign period_o     = period_q;

  // A result beat only appears after a last character beat was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire && last_i))
    else $error("result beat without a final character");

  // The per-message state is back at its idle value after a final beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_i) |=> (cnt_q == '0 && mask_q == ALL_WORDS && !bad_q
                             && ndig_q == 3'd0))
    else $error("message state not cleared after final beat");

  // The report period never leaves its range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (period_q <= PERIOD_MAX) && (digits_q <= PERIOD_MAX))
    else $error("period out of range");

  // While a result is held, the settings it reports must not move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(on_q) && $stable(run_q)
                                       && $stable(scale_q) && $stable(period_q)))
    else $error("settings changed under a held result");

  // An invalid message reports the zero command code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_valid_q) |-> (res_cmd_q == CMD_OFF))
    else $error("invalid result carries a command code");

endmodule

`default_nettype wire

@@ tb/tb_sensor_command_parser.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_command_parser: self-checking bench for the command parser
// Character beats are fed from a queue by a randomly idling driver, and a
// monitor predicts each report from the accepted beats and checks it against
// the report beats taken from the parser under random back-pressure.
// ----------------------------------------------------------------------------

module tb_sensor_command_parser;
  import scp_pkg::*;

  localparam int unsigned MSG_LEN_MAX = 9;
  localparam int unsigned CHAR_TARGET = 1450;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  typedef struct packed {
    logic        ok;
    cmd_e        cmd;
    logic        on;
    logic        run;
    logic        cel;
    logic [13:0] period;
  } report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  ch_i = 8'h00;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        valid_res_o;
  logic [2:0]  command_o;
  logic        powered_on_o;
  logic        running_o;
  logic        celsius_o;
  logic [13:0] period_o;

  sensor_command_parser #(
    .MAX_MSG_LEN(MSG_LEN_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ch_i         (ch_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .valid_res_o  (valid_res_o),
    .command_o    (command_o),
    .powered_on_o (powered_on_o),
    .running_o    (running_o),
    .celsius_o    (celsius_o),
    .period_o     (period_o)
  );

  string kw_off   = "OFF";
  string kw_stop  = "STOP";
  string kw_start = "START";
  string kw_scale = "SCALE";
  string kw_freq  = "FREQ";

  char_beat_t  pending_chars[$];
  report_t     expected_reports[$];
  logic [7:0]  msg_buf[$];
  char_beat_t  next_beat;
  int unsigned chars_queued = 0;
  int unsigned beats_in = 0;
  int unsigned failures = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm;

  // Parser state as the bench sees it
  int unsigned msg_len;
  word_mask_t  alive;
  logic        overlong;
  logic        scale_c;
  int unsigned freq_val;
  int unsigned freq_digits;
  logic        set_on;
  logic        set_run;
  logic        set_cel;
  logic [13:0] set_period;

  // A stretch of the run in which neither side idles.
  assign calm = (beats_in >= 300) && (beats_in < 650);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic clear_message();
    msg_len     = 0;
    alive       = ALL_WORDS;
    overlong    = 1'b0;
    scale_c     = 1'b0;
    freq_val    = 0;
    freq_digits = 0;
  endtask

  task automatic advance_parser(input logic [7:0] c, input logic fin);
    int unsigned p;
    int unsigned v;
    logic        digit;
    report_t     rep;
    p     = msg_len;
    digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    if (p >= MSG_LEN_MAX) begin
      overlong = 1'b1;
    end else begin
      msg_len = p + 1;
    end
    if (!(p < LEN_OFF && kw_off[p] == c)) alive[CMD_OFF] = 1'b0;
    if (!(p < LEN_STOP && kw_stop[p] == c)) alive[CMD_STOP] = 1'b0;
    if (!(p < LEN_START && kw_start[p] == c)) alive[CMD_START] = 1'b0;
    if (p < LEN_SCALE) begin
      if (kw_scale[p] != c) alive[CMD_SCALE] = 1'b0;
    end else if (p == LEN_SCALE) begin
      if (c != CHAR_EQ) alive[CMD_SCALE] = 1'b0;
    end else if (p == POS_SCALE_LETTER) begin
      if (c == CHAR_C) scale_c = 1'b1;
      else if (c == CHAR_F) scale_c = 1'b0;
      else alive[CMD_SCALE] = 1'b0;
    end
    if (p < LEN_FREQ) begin
      if (kw_freq[p] != c) alive[CMD_FREQ] = 1'b0;
    end else if (p == LEN_FREQ) begin
      if (c != CHAR_EQ) alive[CMD_FREQ] = 1'b0;
    end else if (!digit) begin
      alive[CMD_FREQ] = 1'b0;
    end else if (alive[CMD_FREQ] && !overlong) begin
      v = freq_val * 10 + (c - CHAR_ZERO);
      freq_val = (v > PERIOD_MAX) ? PERIOD_MAX : v;
      if (freq_digits < 7) freq_digits++;
    end
    if (fin) begin
      rep.ok  = 1'b0;
      rep.cmd = CMD_OFF;
      if (!overlong) begin
        rep.ok = 1'b1;
        if (alive[CMD_OFF] && msg_len == LEN_OFF) begin
          rep.cmd = CMD_OFF;
          set_on  = 1'b0;
        end else if (alive[CMD_STOP] && msg_len == LEN_STOP) begin
          rep.cmd = CMD_STOP;
          set_run = 1'b0;
        end else if (alive[CMD_START] && msg_len == LEN_START) begin
          rep.cmd = CMD_START;
          set_run = 1'b1;
        end else if (alive[CMD_SCALE] && msg_len >= MIN_LEN_SCALE) begin
          rep.cmd = CMD_SCALE;
          set_cel = scale_c;
        end else if (alive[CMD_FREQ] && msg_len >= MIN_LEN_FREQ && freq_digits > 0) begin
          rep.cmd    = CMD_FREQ;
          set_period = freq_val[13:0];
        end else begin
          rep.ok = 1'b0;
        end
      end
      rep.on     = set_on;
      rep.run    = set_run;
      rep.cel    = set_cel;
      rep.period = set_period;
      expected_reports.push_back(rep);
      clear_message();
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
  endtask

  task automatic add_word(int unsigned w);
    case (w)
      0:       add_text("OFF");
      1:       add_text("STOP");
      2:       add_text("START");
      3:       add_text("SCALE=C");
      default: add_text("FREQ=42");
    endcase
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg_buf.size(); i++) begin
      pending_chars.push_back('{ch: msg_buf[i], last: (i == msg_buf.size() - 1)});
    end
    chars_queued += msg_buf.size();
    msg_buf.delete();
  endtask

  task automatic add_digits(int unsigned n);
    for (int i = 0; i < n; i++) msg_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic build_random_msg();
    int unsigned kind;
    int unsigned r;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      add_text("OFF");
    end else if (kind < 20) begin
      add_text("STOP");
    end else if (kind < 30) begin
      add_text("START");
    end else if (kind < 48) begin
      add_text("SCALE=");
      r = $urandom_range(0, 99);
      if (r < 45) msg_buf.push_back(CHAR_C);
      else if (r < 90) msg_buf.push_back(CHAR_F);
      else msg_buf.push_back(8'($urandom_range(0, 255)));
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) msg_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 68) begin
      add_text("FREQ=");
      add_digits($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 5));
      if ($urandom_range(0, 99) < 15) begin
        msg_buf[$urandom_range(5, msg_buf.size())] = 8'($urandom_range(0, 255));
      end
    end else if (kind < 78) begin
      // A near miss on a real command: one byte replaced, perhaps shortened.
      add_word($urandom_range(0, 4));
      msg_buf[$urandom_range(0, msg_buf.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 2) == 0) void'(msg_buf.pop_back());
      if (msg_buf.size() == 0) msg_buf.push_back(CHAR_EQ);
    end else if (kind < 86) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) msg_buf.push_back(8'("A" + $urandom_range(0, 25)));
      msg_buf.push_back(CHAR_EQ);
      add_digits($urandom_range(1, 2));
    end else if (kind < 93) begin
      add_word($urandom_range(0, 4));
      n = $urandom_range(MSG_LEN_MAX + 1, MSG_LEN_MAX + 5);
      while (msg_buf.size() < n) msg_buf.push_back(8'("A" + $urandom_range(0, 25)));
    end else begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) msg_buf.push_back(8'($urandom_range(0, 255)));
    end
    send_msg();
  endtask

  // Character driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      ch_i       <= 8'h00;
      last_i     <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_chars.size() != 0 && (calm || $urandom_range(0, 99) >= 37)) begin
        next_beat  = pending_chars.pop_front();
        in_valid_i <= 1'b1;
        ch_i       <= next_beat.ch;
        last_i     <= next_beat.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Report receiver, with one long hold-off so that the parser backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (!hold_done && beats_in >= 900) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(0, 99) >= 37);
    end
  end

  // Monitor: reports are checked before the character beat of the same edge
  // is predicted, as a report can never stem from the beat taken with it.
  always @(posedge clk_i) begin : monitor
    report_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: report beat with none expected, got valid %0d command %0d",
                   $time, valid_res_o, command_o);
          failures++;
        end else begin
          want = expected_reports.pop_front();
          check_field("valid_res", want.ok, valid_res_o);
          check_field("command", want.cmd, command_o);
          check_field("powered_on", want.on, powered_on_o);
          check_field("running", want.run, running_o);
          check_field("celsius", want.cel, celsius_o);
          check_field("period", want.period, period_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        advance_parser(ch_i, last_i);
        beats_in++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    set_on     = 1'b1;
    set_run    = 1'b1;
    set_cel    = 1'b0;
    set_period = PERIOD_RESET;
    clear_message();

    add_text("OFF");
    send_msg();
    add_text("STOP");
    send_msg();
    add_text("START");
    send_msg();
    add_text("SCALE=C");
    send_msg();
    add_text("FREQ=0");
    send_msg();
    msg_buf.push_back(8'hFF);
    send_msg();
    msg_buf.push_back(8'h00);
    send_msg();
    while (chars_queued < CHAR_TARGET) build_random_msg();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_chars.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/scp_pkg.sv
rtl/sensor_command_parser.sv
tb/tb_sensor_command_parser.sv
